// File: rtl/mmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer package
// Parser state codes, token codes, character constants and the event record
// that travels from the parser to the output stage.
// ----------------------------------------------------------------------------
package mmt_pkg;

   localparam int POS_WIDTH_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int SPAN_WIDTH      = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int TOK_WIDTH       = 3;

   localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_F  = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_R  = 8'h72;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_O  = 8'h6F;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_M  = 8'h6D;

   typedef enum logic [4:0] {
      ST_ENTRY      = 5'd0,
      ST_HEADERS    = 5'd1,
      ST_HEADERS_CR = 5'd2,
      ST_FIELD_NAME = 5'd3,
      ST_COLON      = 5'd4,
      ST_FIELD_BODY = 5'd5,
      ST_FB_CR      = 5'd6,
      ST_FB_CRLF    = 5'd7,
      ST_BODY       = 5'd8,
      ST_BODY_CR    = 5'd9,
      ST_FROM_F     = 5'd10,
      ST_FROM_R     = 5'd11,
      ST_FROM_O     = 5'd12,
      ST_FROM_M     = 5'd13,
      ST_MBREAK     = 5'd14,
      ST_MBREAK_CR  = 5'd15,
      ST_MBREAK_LF  = 5'd16
   } parse_state_type;

   typedef enum logic [TOK_WIDTH-1:0] {
      TK_ERR        = 3'd0,
      TK_FIELD_NAME = 3'd1,
      TK_COLON      = 3'd2,
      TK_FIELD_BODY = 3'd3,
      TK_BODY       = 3'd4,
      TK_BREAK      = 3'd5
   } tok_code_type;

   typedef enum logic {
      EV_TOKEN   = 1'b0,
      EV_NEWLINE = 1'b1
   } ev_kind_type;

   // One parsed byte worth of events: a token span, optionally followed by
   // a newline span.
   typedef struct packed {
      logic                  pair;
      tok_code_type          tok;
      logic [SPAN_WIDTH-1:0] tok_start;
      logic [SPAN_WIDTH-1:0] tok_end;
      logic [SPAN_WIDTH-1:0] nl_start;
      logic [SPAN_WIDTH-1:0] nl_end;
   } evt_rec_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

endpackage

// File: rtl/mmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer parser
// Takes one byte per cycle while byte_accept is high, advances the parse
// state and pushes the token and newline spans that the byte closes.
// ----------------------------------------------------------------------------
module mmt_front #(
   parameter int POS_WIDTH = mmt_pkg::POS_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_accept,
   input  logic [mmt_pkg::BYTE_WIDTH-1:0]   byte_value,
   output logic                             push,
   output mmt_pkg::evt_rec_type             push_rec
);
   import mmt_pkg::*;

   typedef struct packed {
      parse_state_type      st;
      tok_code_type         tok;
      logic [POS_WIDTH-1:0] start;
      logic [POS_WIDTH-1:0] brk;
      logic                 again;
      logic                 emit_tok;
      logic                 emit_nl;
      tok_code_type         ev_tok;
      logic [POS_WIDTH-1:0] ev_start;
      logic [POS_WIDTH-1:0] ev_end;
   } step_type;

   function automatic step_type step(
      input parse_state_type      st,
      input logic [BYTE_WIDTH-1:0] c,
      input logic [POS_WIDTH-1:0] pos,
      input tok_code_type         tok,
      input logic [POS_WIDTH-1:0] start,
      input logic [POS_WIDTH-1:0] brk
   );
      step_type r;
      r.st       = st;
      r.tok      = tok;
      r.start    = start;
      r.brk      = brk;
      r.again    = 1'b0;
      r.emit_tok = 1'b0;
      r.emit_nl  = 1'b0;
      r.ev_tok   = tok;
      r.ev_start = start;
      r.ev_end   = pos;
      case (st)
         ST_HEADERS: begin
            if (c == CH_CR) begin
               r.tok = TK_BODY;
               r.st  = ST_HEADERS_CR;
            end else if (c == CH_LF) begin
               r.tok = TK_BODY;
               r.st  = ST_BODY_CR;
            end else begin
               r.tok = TK_FIELD_NAME;
               r.st  = ST_FIELD_NAME;
            end
         end
         ST_HEADERS_CR: begin
            if (c == CH_LF) begin
               r.st = ST_BODY_CR;
            end else begin
               r.st    = ST_HEADERS;
               r.again = 1'b1;
            end
         end
         ST_FIELD_NAME: begin
            if (c == CH_COLON) begin
               r.emit_tok = 1'b1;
               r.tok      = TK_COLON;
               r.start    = pos;
               r.st       = ST_COLON;
            end
         end
         ST_COLON: begin
            // close the colon and look at this byte again as field body
            r.emit_tok = 1'b1;
            r.tok      = TK_FIELD_BODY;
            r.start    = pos;
            r.st       = ST_FIELD_BODY;
            r.again    = 1'b1;
         end
         ST_FIELD_BODY: begin
            if (c == CH_CR) begin
               r.brk = pos;
               r.st  = ST_FB_CR;
            end else if (c == CH_LF) begin
               r.brk = pos;
               r.st  = ST_FB_CRLF;
            end
         end
         ST_FB_CR: begin
            r.st = (c == CH_LF) ? ST_FB_CRLF : ST_FIELD_BODY;
         end
         ST_FB_CRLF: begin
            if (c == CH_SPACE || c == CH_TAB) begin
               r.st = ST_FIELD_BODY;
            end else begin
               // unfolded line: close the field body and the newline
               r.emit_tok = 1'b1;
               r.emit_nl  = 1'b1;
               r.ev_end   = brk;
               r.tok      = TK_ERR;
               r.start    = pos;
               r.st       = ST_HEADERS;
               r.again    = 1'b1;
            end
         end
         ST_BODY: begin
            if (c == CH_CR || c == CH_LF) begin
               r.st = ST_BODY_CR;
            end
         end
         ST_BODY_CR: begin
            if (c == CH_UP_F) begin
               r.st = ST_FROM_F;
            end else begin
               r.st    = ST_BODY;
               r.again = 1'b1;
            end
         end
         ST_FROM_F: begin
            if (c == CH_LO_R) begin
               r.st = ST_FROM_R;
            end else begin
               r.st    = ST_BODY;
               r.again = 1'b1;
            end
         end
         ST_FROM_R: begin
            if (c == CH_LO_O) begin
               r.st = ST_FROM_O;
            end else begin
               r.st    = ST_BODY;
               r.again = 1'b1;
            end
         end
         ST_FROM_O: begin
            if (c == CH_LO_M) begin
               r.st = ST_FROM_M;
            end else begin
               r.st    = ST_BODY;
               r.again = 1'b1;
            end
         end
         ST_FROM_M: begin
            // the break began four bytes back, at the F
            r.emit_tok = (pos > POS_WIDTH'(4));
            r.ev_end   = pos - POS_WIDTH'(4);
            r.start    = pos - POS_WIDTH'(4);
            r.tok      = TK_BREAK;
            r.st       = ST_MBREAK;
            r.again    = 1'b1;
         end
         ST_MBREAK: begin
            if (c == CH_CR) begin
               r.st = ST_MBREAK_CR;
            end else if (c == CH_LF) begin
               r.st = ST_MBREAK_LF;
            end
         end
         ST_MBREAK_CR: begin
            r.emit_tok = 1'b1;
            r.ev_end   = pos - POS_WIDTH'(1);
            r.st       = ST_HEADERS;
            if (c == CH_LF) begin
               r.start = pos + POS_WIDTH'(1);
            end else begin
               r.start = pos;
               r.again = 1'b1;
            end
         end
         ST_MBREAK_LF: begin
            r.emit_tok = 1'b1;
            r.ev_end   = pos - POS_WIDTH'(1);
            r.start    = pos;
            r.st       = ST_HEADERS;
            r.again    = 1'b1;
         end
         default: begin
            if (c == CH_UP_F) begin
               r.st = ST_FROM_F;
            end else begin
               r.st    = ST_HEADERS;
               r.again = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   parse_state_type      state_ff, state_in;
   tok_code_type         tok_ff, tok_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic [POS_WIDTH-1:0] brk_ff, brk_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   step_type             first_step, second_step, final_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ENTRY;
         tok_ff   <= TK_ERR;
         start_ff <= '0;
         brk_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in;
         start_ff <= start_in;
         brk_ff   <= brk_in;
         pos_ff   <= pos_in;
      end
   end

   // Only the first pass can emit; a re-examined byte lands in a state
   // that merely moves on.
   always_comb begin
      first_step  = step(state_ff, byte_value, pos_ff, tok_ff, start_ff, brk_ff);
      second_step = step(first_step.st, byte_value, pos_ff, first_step.tok,
                         first_step.start, first_step.brk);
      final_step  = first_step.again ? second_step : first_step;

      state_in = state_ff;
      tok_in   = tok_ff;
      start_in = start_ff;
      brk_in   = brk_ff;
      pos_in   = pos_ff;
      if (byte_accept) begin
         state_in = final_step.st;
         tok_in   = final_step.tok;
         start_in = final_step.start;
         brk_in   = final_step.brk;
         pos_in   = pos_ff + POS_WIDTH'(1);
      end

      push               = byte_accept && first_step.emit_tok;
      push_rec.pair      = first_step.emit_nl;
      push_rec.tok       = first_step.ev_tok;
      push_rec.tok_start = SPAN_WIDTH'(first_step.ev_start);
      push_rec.tok_end   = SPAN_WIDTH'(first_step.ev_end);
      push_rec.nl_start  = SPAN_WIDTH'(first_step.brk);
      push_rec.nl_end    = SPAN_WIDTH'(pos_ff);
   end

endmodule

// File: rtl/mmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer event queue
// Short first-in first-out buffer of event records between the parser and
// the output stage.
// ----------------------------------------------------------------------------
module mmt_queue #(
   parameter int DEPTH = mmt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mmt_pkg::evt_rec_type  push_rec,
   input  logic                  pop,
   output mmt_pkg::evt_rec_type  head_rec,
   output mmt_pkg::q_stat_type   stat
);
   import mmt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   evt_rec_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && stat.valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: rtl/mmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer output stage
// Splits each event record into one or two beats and holds them in an
// output register until the receiver takes them.
// ----------------------------------------------------------------------------
module mmt_back (
   input  logic                            clock,
   input  logic                            reset,
   input  mmt_pkg::evt_rec_type            head_rec,
   input  mmt_pkg::q_stat_type             stat,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*mmt_pkg::SPAN_WIDTH-1:0] rsp_tdata,
   output logic [mmt_pkg::TOK_WIDTH:0]     rsp_tuser,
   output logic                            rsp_tlast
);
   import mmt_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  phase_ff, phase_in;
   ev_kind_type           kind_ff, kind_in;
   tok_code_type          tok_ff, tok_in;
   logic [SPAN_WIDTH-1:0] start_ff, start_in;
   logic [SPAN_WIDTH-1:0] end_ff, end_in;
   logic                  last_ff, last_in;
   logic                  load;

   always_comb begin
      load     = stat.valid && (!valid_ff || rsp_tready);
      pop      = load && (phase_ff || !head_rec.pair);
      valid_in = valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      tok_in   = tok_ff;
      start_in = start_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         if (phase_ff) begin
            kind_in  = EV_NEWLINE;
            tok_in   = TK_ERR;
            start_in = head_rec.nl_start;
            end_in   = head_rec.nl_end;
            last_in  = 1'b1;
            phase_in = 1'b0;
         end else begin
            kind_in  = EV_TOKEN;
            tok_in   = head_rec.tok;
            start_in = head_rec.tok_start;
            end_in   = head_rec.tok_end;
            last_in  = !head_rec.pair;
            phase_in = head_rec.pair;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      tok_ff   <= tok_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {end_ff, start_ff};
   assign rsp_tuser  = {tok_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/mail_message_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer
// Splits an mbox-style message byte stream into field name, colon, field
// body, message body and message break spans plus newline spans.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one raw message byte per beat. rsp_* returns spans as byte
//   offsets from reset: start and exclusive end in tdata, event kind and
//   token type in tuser. tlast marks the final span caused by one byte.
//   A byte causes zero, one or two spans; bytes that close nothing give
//   no beat at all.
//   Throughput: one byte per cycle while rsp keeps up. The parser resolves
//   each byte, re-examinations included, in combinational logic. Each span
//   is one rsp beat, so a byte that closes a field line gives two beats.
//   A run of one-letter header lines gives four spans for three bytes; the
//   queue then fills and req_tready drops while the extra beats drain.
//   The first span of a byte is written into the queue and then loaded into
//   the output register before it is on rsp.
//   Reset: the parser returns to the first-byte state with all offsets at
//   zero and the queue empties. When the receiver stalls, spans collect in
//   the queue and req_tready drops once it is full; bytes are held off
//   until a record drains.
// ----------------------------------------------------------------------------
module mail_message_tokenizer #(
   parameter int POS_WIDTH   = mmt_pkg::POS_WIDTH_DEF,
   parameter int QUEUE_DEPTH = mmt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mmt_pkg::BYTE_WIDTH-1:0]   req_tdata,   // [7:0] byte_value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2*mmt_pkg::SPAN_WIDTH-1:0] rsp_tdata,   // [31:0] span_start, [63:32] span_end
   output logic [mmt_pkg::TOK_WIDTH:0]      rsp_tuser,   // [0] event_kind, [3:1] token_type
   output logic                             rsp_tlast    // last_of_run
);
   import mmt_pkg::*;

   logic        byte_accept;
   logic        push;
   logic        pop;
   evt_rec_type push_rec;
   evt_rec_type head_rec;
   q_stat_type  stat;

   assign req_tready  = !stat.full;
   assign byte_accept = req_tvalid && req_tready;

   mmt_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_value  (req_tdata),
      .push        (push),
      .push_rec    (push_rec)
   );

   mmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (stat)
   );

   mmt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a newline span always closes the run of its byte
   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("newline beat without tlast");

   // a newline span carries token type zero
   a_newline_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[TOK_WIDTH:1] == TK_ERR)
      else $error("newline beat with nonzero token type");

   // a token beat that is not last is followed at once by its newline beat
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser[0])
      else $error("field body beat not followed by its newline beat");

   // a push is never dropped by a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("event record pushed into a full queue");

endmodule

// File: tb/span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span checker
// Watches the byte stream going into the mail message tokenizer. It tracks
// the parser state on its own and works out the token and newline spans that
// each accepted byte must produce. Spans leaving on rsp are compared in order
// against that list. It reports the mismatch count and the spans still owed.
// ----------------------------------------------------------------------------
module span_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] span_start, [63:32] span_end
   input  logic [3:0]  rsp_tuser,   // [0] event_kind, [3:1] token_type
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          spans_waiting
);
   import mmt_pkg::*;

   typedef struct packed {
      ev_kind_type  kind;
      tok_code_type tok;
      logic [31:0]  span_start;
      logic [31:0]  span_end;
      logic         last;
   } span_rec_type;

   span_rec_type spans_due[$];

   // parser image
   parse_state_type pstate    = ST_ENTRY;
   tok_code_type    cur_tok   = TK_ERR;
   logic [31:0]     tok_start = '0;
   logic [31:0]     brk_pos   = '0;
   logic [31:0]     byte_pos  = '0;

   span_rec_type fresh[2];
   int           n_fresh;
   int           bad_spans = 0;

   function automatic void add_span(ev_kind_type kind, tok_code_type tok,
                                    logic [31:0] s, logic [31:0] e);
      if (n_fresh < 2) begin
         fresh[n_fresh] = '{kind, tok, s, e, 1'b0};
         n_fresh++;
      end
   endfunction

   function automatic void tokenize_byte(logic [7:0] c);
      logic [31:0]     pos;
      parse_state_type st;
      bit              again;
      pos     = byte_pos;
      st      = pstate;
      again   = 1'b1;
      n_fresh = 0;
      while (again) begin
         again = 1'b0;
         case (st)
            ST_HEADERS: begin
               if (c == CH_CR) begin
                  cur_tok = TK_BODY;
                  st      = ST_HEADERS_CR;
               end else if (c == CH_LF) begin
                  cur_tok = TK_BODY;
                  st      = ST_BODY_CR;
               end else begin
                  cur_tok = TK_FIELD_NAME;
                  st      = ST_FIELD_NAME;
               end
            end
            ST_HEADERS_CR: begin
               if (c == CH_LF) begin
                  st = ST_BODY_CR;
               end else begin
                  st    = ST_HEADERS;
                  again = 1'b1;
               end
            end
            ST_FIELD_NAME: begin
               if (c == CH_COLON) begin
                  add_span(EV_TOKEN, cur_tok, tok_start, pos);
                  cur_tok   = TK_COLON;
                  tok_start = pos;
                  st        = ST_COLON;
               end
            end
            ST_COLON: begin
               // the byte after the colon is looked at again as field body
               add_span(EV_TOKEN, cur_tok, tok_start, pos);
               cur_tok   = TK_FIELD_BODY;
               tok_start = pos;
               st        = ST_FIELD_BODY;
               again     = 1'b1;
            end
            ST_FIELD_BODY: begin
               if (c == CH_CR) begin
                  brk_pos = pos;
                  st      = ST_FB_CR;
               end else if (c == CH_LF) begin
                  brk_pos = pos;
                  st      = ST_FB_CRLF;
               end
            end
            ST_FB_CR: begin
               st = (c == CH_LF) ? ST_FB_CRLF : ST_FIELD_BODY;
            end
            ST_FB_CRLF: begin
               if (c == CH_SPACE || c == CH_TAB) begin
                  st = ST_FIELD_BODY;
               end else begin
                  add_span(EV_TOKEN, cur_tok, tok_start, brk_pos);
                  cur_tok = TK_ERR;
                  add_span(EV_NEWLINE, TK_ERR, brk_pos, pos);
                  tok_start = pos;
                  st        = ST_HEADERS;
                  again     = 1'b1;
               end
            end
            ST_BODY: begin
               if (c == CH_CR || c == CH_LF) st = ST_BODY_CR;
            end
            ST_BODY_CR: begin
               if (c == CH_UP_F) begin
                  st = ST_FROM_F;
               end else begin
                  st    = ST_BODY;
                  again = 1'b1;
               end
            end
            ST_FROM_F: begin
               if (c == CH_LO_R) begin
                  st = ST_FROM_R;
               end else begin
                  st    = ST_BODY;
                  again = 1'b1;
               end
            end
            ST_FROM_R: begin
               if (c == CH_LO_O) begin
                  st = ST_FROM_O;
               end else begin
                  st    = ST_BODY;
                  again = 1'b1;
               end
            end
            ST_FROM_O: begin
               if (c == CH_LO_M) begin
                  st = ST_FROM_M;
               end else begin
                  st    = ST_BODY;
                  again = 1'b1;
               end
            end
            ST_FROM_M: begin
               // no body span when the break sits at the head of the stream
               if (pos > 32'd4) add_span(EV_TOKEN, cur_tok, tok_start, pos - 32'd4);
               tok_start = pos - 32'd4;
               cur_tok   = TK_BREAK;
               st        = ST_MBREAK;
               again     = 1'b1;
            end
            ST_MBREAK: begin
               if (c == CH_CR) st = ST_MBREAK_CR;
               else if (c == CH_LF) st = ST_MBREAK_LF;
            end
            ST_MBREAK_CR: begin
               add_span(EV_TOKEN, cur_tok, tok_start, pos - 32'd1);
               st = ST_HEADERS;
               if (c == CH_LF) begin
                  tok_start = pos + 32'd1;
               end else begin
                  tok_start = pos;
                  again     = 1'b1;
               end
            end
            ST_MBREAK_LF: begin
               add_span(EV_TOKEN, cur_tok, tok_start, pos - 32'd1);
               tok_start = pos;
               st        = ST_HEADERS;
               again     = 1'b1;
            end
            default: begin
               if (c == CH_UP_F) begin
                  st = ST_FROM_F;
               end else begin
                  st    = ST_HEADERS;
                  again = 1'b1;
               end
            end
         endcase
      end
      pstate   = st;
      byte_pos = pos + 32'd1;
      if (n_fresh > 0) fresh[n_fresh-1].last = 1'b1;
      for (int k = 0; k < n_fresh; k++) spans_due.push_back(fresh[k]);
   endfunction

   function automatic void report_mismatch(string what, span_rec_type want,
                                           span_rec_type got);
      bad_spans++;
      if (bad_spans <= 10) begin
         $display("%0t %s: expected kind=%0d tok=%0d start=%0d end=%0d last=%0d",
                  $time, what, want.kind, want.tok, want.span_start, want.span_end,
                  want.last);
         $display("%0t %s:   actual kind=%0d tok=%0d start=%0d end=%0d last=%0d",
                  $time, what, got.kind, got.tok, got.span_start, got.span_end, got.last);
      end
   endfunction

   always @(posedge clock) begin : watch
      span_rec_type got;
      span_rec_type want;
      if (reset) begin
         pstate    = ST_ENTRY;
         cur_tok   = TK_ERR;
         tok_start = '0;
         brk_pos   = '0;
         byte_pos  = '0;
         spans_due.delete();
      end else begin
         if (req_tvalid && req_tready) tokenize_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = ev_kind_type'(rsp_tuser[0]);
            got.tok        = tok_code_type'(rsp_tuser[3:1]);
            got.span_start = rsp_tdata[31:0];
            got.span_end   = rsp_tdata[63:32];
            got.last       = rsp_tlast;
            if (spans_due.size() == 0) begin
               report_mismatch("span with none expected", '0, got);
            end else begin
               want = spans_due.pop_front();
               if (got !== want) report_mismatch("span mismatch", want, got);
            end
         end
      end
      mismatches    <= bad_spans;
      spans_waiting <= spans_due.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail message tokenizer testbench
// Feeds a short directed byte sequence and then mbox-style messages with
// random content and noise bursts. Sender and receiver stall at random
// in two of three phases. A span checker predicts and compares every rsp beat.
// ----------------------------------------------------------------------------
module testbench;
   import mmt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int STREAM_BYTES = 1050;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;      // [7:0] byte_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;            // [31:0] span_start, [63:32] span_end
   logic [3:0]  rsp_tuser;            // [0] event_kind, [3:1] token_type
   logic        rsp_tlast;

   int          mismatches;
   int          spans_waiting;
   int unsigned cycle_count = 0;
   int          send_idle   = 32;
   int          recv_idle   = 79;
   logic [7:0]  stream_q[$];

   mail_message_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   span_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .spans_waiting (spans_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready  <= ($urandom_range(99) >= recv_idle);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void put_str(string s);
      for (int k = 0; k < s.len(); k++) stream_q.push_back(s[k]);
   endfunction

   function automatic void put_eol();
      int r;
      r = $urandom_range(9);
      if (r < 6) begin
         stream_q.push_back(CH_CR);
         stream_q.push_back(CH_LF);
      end else if (r < 9) begin
         stream_q.push_back(CH_LF);
      end else begin
         stream_q.push_back(CH_CR);
      end
   endfunction

   // mostly printable, now and then any byte at all
   function automatic void put_text(int n);
      repeat (n) begin
         if ($urandom_range(9) == 0) stream_q.push_back(8'($urandom_range(255)));
         else stream_q.push_back(8'($urandom_range(126, 32)));
      end
   endfunction

   function automatic void put_message();
      int r;
      put_str("From ");
      put_text($urandom_range(12, 3));
      put_eol();
      repeat ($urandom_range(4, 1)) begin
         repeat ($urandom_range(8, 1)) stream_q.push_back(8'($urandom_range(90, 65)));
         stream_q.push_back(CH_COLON);
         if ($urandom_range(1)) stream_q.push_back(CH_SPACE);
         put_text($urandom_range(20));
         put_eol();
         // folded continuation line
         if ($urandom_range(3) == 0) begin
            stream_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            put_text($urandom_range(15));
            put_eol();
         end
      end
      put_eol();
      repeat ($urandom_range(4)) begin
         r = $urandom_range(9);
         if (r < 2) put_str("From ");
         else if (r < 4) put_str("Fro");
         put_text($urandom_range(30));
         put_eol();
      end
   endfunction

   function automatic void put_noise();
      repeat ($urandom_range(30, 5)) stream_q.push_back(8'($urandom_range(255)));
      put_eol();
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every owed span has come back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (spans_waiting != 0);
   endtask

   initial begin : stimulus
      int phase;
      int seen_phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // break at offset zero ending in a lone CR, empty field body, tab fold,
      // CR without LF in a field body, NUL, From after body LF, blank CRLF
      put_str("From\015X:\015\n\t\015");
      stream_q.push_back(8'hFF);
      put_str("\n\n");
      stream_q.push_back(8'h00);
      put_str("\nFrom \n\015\n");
      foreach (stream_q[i]) send_byte(stream_q[i]);
      hold_until_drained();

      stream_q.delete();
      while (stream_q.size() < STREAM_BYTES) begin
         if ($urandom_range(99) < 15) put_noise();
         else put_message();
      end

      seen_phase = 0;
      for (int i = 0; i < stream_q.size(); i++) begin
         phase = i * 3 / stream_q.size();
         if (phase != seen_phase) begin
            hold_until_drained();
            seen_phase = phase;
            send_idle  = (phase == 1) ? 79 : 0;
            recv_idle  = (phase == 1) ? 32 : 0;
         end
         send_byte(stream_q[i]);
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (spans_waiting != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && spans_waiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
